/* hw/rtl/true_peak_meter_fir_defines.svh */
// Assertion macros for the true-peak meter checker.
// Clocked on clock, disabled while reset is high; no other dependencies.
`ifndef TRUE_PEAK_METER_FIR_DEFINES_SVH
`define TRUE_PEAK_METER_FIR_DEFINES_SVH

// Same-cycle implication
`define TPM_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tpm assertion failed");

// Next-cycle implication
`define TPM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tpm assertion failed");

`endif

/* hw/rtl/tpm_pkg.sv */
// Shared widths, types and coefficient tables of the true-peak meter.
// No dependencies; used by the interfaces, the cells, the reduce pipe and the top.
package tpm_pkg;

   localparam int SAMPLE_WIDTH    = 24;
   localparam int TAP_COUNT       = 7;
   localparam int CENTER_TAP      = 3;
   localparam int PHASE_COUNT     = 4;
   localparam int COEF_FRAC_BITS  = 17;
   localparam int TABLE_FRAC_BITS = 24;
   localparam int ROUND_SHIFT     = TABLE_FRAC_BITS - COEF_FRAC_BITS;
   localparam int COEF_WIDTH      = COEF_FRAC_BITS + 1;
   localparam int PROD_WIDTH      = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int SUM_WIDTH       = PROD_WIDTH + $clog2(TAP_COUNT);
   localparam int PAIR_COUNT      = (TAP_COUNT + 1) / 2;
   localparam int PIPE_STAGES     = 6;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic        [SAMPLE_WIDTH-1:0] peak_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [SUM_WIDTH-1:0]    sum_type;

   localparam sum_type SUM_HALF   = sum_type'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam sum_type PEAK_LIMIT = sum_type'(peak_type'('1));

   // Q1.24 tables
   localparam int TABLE_A [TAP_COUNT] = '{
      569862, -2126314, 9663647, 11059747, -3260706, 1313006, -432984
   };
   localparam int TABLE_B [TAP_COUNT] = '{
      362658, -1264971, 4451736, 15236589, -2687305, 998070, -316474
   };

   function automatic coef_type coef_of(input int phase, input int tap);
      int q;
      int rev;
      rev = TAP_COUNT - 1 - tap;
      case (phase)
         0:       q = TABLE_A[tap];
         1:       q = TABLE_B[tap];
         2:       q = TABLE_B[rev];
         default: q = TABLE_A[rev];
      endcase
      return coef_type'((q + ((1 << ROUND_SHIFT) >> 1)) >>> ROUND_SHIFT);
   endfunction

endpackage

/* hw/rtl/tpm_req_if.sv */
// Sample channel: valid/ready handshake carrying one audio sample.
// Depends on tpm_pkg.
interface tpm_req_if;
   import tpm_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

/* hw/rtl/tpm_rsp_if.sv */
// Peak channel: valid/ready handshake carrying one true-peak estimate.
// Depends on tpm_pkg.
interface tpm_rsp_if;
   import tpm_pkg::*;
   logic     valid;
   logic     ready;
   peak_type peak;
   modport source (output valid, output peak, input ready);
   modport sink (input valid, input peak, output ready);
endinterface

/* hw/rtl/tpm_tap_cell.sv */
// One delay-line cell: holds one tap, passes it to its older neighbor,
// and registers its product with each of the four phase coefficients. Depends on tpm_pkg.
module tpm_tap_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic              advance,
   input  tpm_pkg::sample_type sample_i,
   input  tpm_pkg::coef_type coef_i [tpm_pkg::PHASE_COUNT],
   output tpm_pkg::sample_type sample_o,
   output tpm_pkg::prod_type prod_o [tpm_pkg::PHASE_COUNT]
);
   import tpm_pkg::*;

   sample_type tap_ff;
   sample_type tap_in;
   prod_type   prod_ff [PHASE_COUNT];
   prod_type   prod_in [PHASE_COUNT];

   always_comb begin
      tap_in = shift_en ? sample_i : tap_ff;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         prod_in[p] = advance ? prod_type'(tap_ff) * prod_type'(coef_i[p]) : prod_ff[p];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign sample_o = tap_ff;
   assign prod_o   = prod_ff;
endmodule

/* hw/rtl/tpm_peak_reduce.sv */
// Reduce pipe: sums the cell products per phase, rounds to sample scale,
// takes magnitudes, saturates and picks the largest with the center tap. Depends on tpm_pkg.
module tpm_peak_reduce (
   input  logic                clock,
   input  logic                advance,
   input  tpm_pkg::sample_type center_i,
   input  tpm_pkg::prod_type   prod_i [tpm_pkg::TAP_COUNT][tpm_pkg::PHASE_COUNT],
   output tpm_pkg::peak_type   peak_o
);
   import tpm_pkg::*;

   peak_type c1_ff, c1_in, c2_ff, c3_ff, c4_ff;
   sum_type  pair_ff  [PHASE_COUNT][PAIR_COUNT];
   sum_type  pair_in  [PHASE_COUNT][PAIR_COUNT];
   sum_type  total_ff [PHASE_COUNT];
   sum_type  total_in [PHASE_COUNT];
   peak_type mag_ff   [PHASE_COUNT];
   peak_type mag_in   [PHASE_COUNT];
   peak_type peak_ff, peak_in;
   sum_type  rnd;
   sum_type  mag;

   always_comb begin
      c1_in = center_i[SAMPLE_WIDTH-1] ? peak_type'(~center_i + 1'b1) : peak_type'(center_i);
      for (int p = 0; p < PHASE_COUNT; p++) begin
         for (int j = 0; j < PAIR_COUNT; j++) begin
            pair_in[p][j] = sum_type'(prod_i[2*j][p]);
            if (2*j + 1 < TAP_COUNT) begin
               pair_in[p][j] = pair_in[p][j] + sum_type'(prod_i[(2*j + 1) % TAP_COUNT][p]);
            end
         end
      end
   end

   always_comb begin
      for (int p = 0; p < PHASE_COUNT; p++) begin
         total_in[p] = '0;
         for (int j = 0; j < PAIR_COUNT; j++) begin
            total_in[p] = total_in[p] + pair_ff[p][j];
         end
      end
   end

   always_comb begin
      rnd = '0;
      mag = '0;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         rnd = (total_ff[p] + SUM_HALF) >>> COEF_FRAC_BITS;
         mag = rnd[SUM_WIDTH-1] ? -rnd : rnd;
         mag_in[p] = (mag > PEAK_LIMIT) ? '1 : peak_type'(mag);
      end
   end

   always_comb begin
      peak_in = c4_ff;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (mag_ff[p] > peak_in) begin
            peak_in = mag_ff[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff    <= c1_in;
         pair_ff  <= pair_in;
         c2_ff    <= c1_ff;
         total_ff <= total_in;
         c3_ff    <= c2_ff;
         mag_ff   <= mag_in;
         c4_ff    <= c3_ff;
         peak_ff  <= peak_in;
      end
   end

   assign peak_o = peak_ff;
endmodule

/* hw/rtl/true_peak_meter_fir.sv */
// True-peak meter with a 4x oversampling polyphase FIR. It takes one sample
// per cycle while the pipe is not held and returns one peak item per sample.
// The seven-tap delay line is a row of cells that each multiply their tap by
// the four phase coefficients; a four-stage pipe then sums, rounds, takes
// magnitudes and selects the maximum. When a result is not taken the whole
// pipe holds, and req_chan.ready follows rsp_chan.ready in that cycle.
module true_peak_meter_fir (
   input logic        clock,
   input logic        reset,
   tpm_req_if.sink    req_chan,
   tpm_rsp_if.source  rsp_chan
);
   import tpm_pkg::*;

   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   logic                   advance;
   logic                   accept;
   sample_type             tap_w  [TAP_COUNT];
   prod_type               prod_w [TAP_COUNT][PHASE_COUNT];
   coef_type               coef_w [TAP_COUNT][PHASE_COUNT];

   assign advance = !valid_ff[PIPE_STAGES-1] || rsp_chan.ready;
   assign accept  = req_chan.valid && advance;

   always_comb begin
      valid_in = advance ? {valid_ff[PIPE_STAGES-2:0], req_chan.valid} : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   for (genvar t = 0; t < TAP_COUNT; t++) begin : g_cell
      for (genvar p = 0; p < PHASE_COUNT; p++) begin : g_coef
         assign coef_w[t][p] = coef_of(p, t);
      end
      tpm_tap_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .advance  (advance),
         .sample_i ((t == TAP_COUNT - 1) ? req_chan.sample : tap_w[(t + 1) % TAP_COUNT]),
         .coef_i   (coef_w[t]),
         .sample_o (tap_w[t]),
         .prod_o   (prod_w[t])
      );
   end

   tpm_peak_reduce u_reduce (
      .clock    (clock),
      .advance  (advance),
      .center_i (tap_w[CENTER_TAP]),
      .prod_i   (prod_w),
      .peak_o   (rsp_chan.peak)
   );

   assign req_chan.ready = advance;
   assign rsp_chan.valid = valid_ff[PIPE_STAGES-1];
endmodule

/* hw/rtl/tpm_checker.sv */
// Port-level checks of the true-peak meter, bound to the top level.
// Depends on tpm_pkg and true_peak_meter_fir_defines.svh.
`include "true_peak_meter_fir_defines.svh"
module tpm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input tpm_pkg::sample_type req_sample,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input tpm_pkg::peak_type  rsp_peak
);
   import tpm_pkg::*;

   `TPM_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_sample))
   `TPM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_peak))
   `TPM_ASSERT_IMPLY(a_stall_cause, !req_ready, rsp_valid && !rsp_ready)
   `TPM_ASSERT_IMPLY(a_empty_after_reset, $fell(reset), !rsp_valid ##1 !rsp_valid)
endmodule

bind true_peak_meter_fir tpm_checker u_tpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_sample (req_chan.sample),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_peak   (rsp_chan.peak)
);

/* tb/sv/tb.sv */
// Self-checking bench for true_peak_meter_fir: drives signed samples over the
// request channel and checks every peak item against a scoreboard predictor.
// Depends on tpm_pkg, tpm_req_if, tpm_rsp_if and the RTL of the meter.
`timescale 1ns / 1ps

module tb;
   import tpm_pkg::*;

   localparam int  CYCLE_LIMIT   = 200000;
   localparam int  PHASE_ITEMS   = 200;
   localparam int  DRAIN_CYCLES  = 16;
   localparam longint FULL_POS   = 64'sd8388607;
   localparam longint FULL_NEG   = -64'sd8388608;
   // taps with a negative weight in the forward and in the reversed phases
   localparam bit [6:0] NEG_FWD  = 7'b1010010;
   localparam bit [6:0] NEG_REV  = 7'b0100101;

   class peak_scoreboard;
      sample_type history [7];
      peak_type   pending_peaks [$];
      int         errors;

      localparam longint WEIGHT_A [7] = '{
         569862, -2126314, 9663647, 11059747, -3260706, 1313006, -432984
      };
      localparam longint WEIGHT_B [7] = '{
         362658, -1264971, 4451736, 15236589, -2687305, 998070, -316474
      };

      function new();
         foreach (history[i]) history[i] = '0;
         errors = 0;
      endfunction

      function longint tap_weight(int phase, int tap);
         longint q;
         case (phase)
            0:       q = WEIGHT_A[tap];
            1:       q = WEIGHT_B[tap];
            2:       q = WEIGHT_B[6 - tap];
            default: q = WEIGHT_A[6 - tap];
         endcase
         return (q + 64'sd64) >>> 7;
      endfunction

      function void note_sample(sample_type s);
         longint acc;
         longint mag;
         longint best;
         for (int i = 0; i < 6; i++) history[i] = history[i + 1];
         history[6] = s;
         best = longint'(history[3]);
         if (best < 0) best = -best;
         for (int p = 0; p < 4; p++) begin
            acc = 0;
            for (int i = 0; i < 7; i++) acc += longint'(history[i]) * tap_weight(p, i);
            mag = (acc + 64'sd65536) >>> 17;
            if (mag < 0) mag = -mag;
            if (mag > best) best = mag;
         end
         if (best > 64'sd16777215) best = 64'sd16777215;
         pending_peaks.push_back(peak_type'(best));
      endfunction

      function void check_peak(peak_type got);
         peak_type want;
         if (pending_peaks.size() == 0) begin
            $display("%0t: unexpected peak item, got %0d", $time, got);
            errors++;
            return;
         end
         want = pending_peaks.pop_front();
         if (got !== want) begin
            $display("%0t: peak mismatch, expected %0d, actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   send_idle_pct;
   int   recv_idle_pct;
   peak_scoreboard sb;

   tpm_req_if req_chan ();
   tpm_rsp_if rsp_chan ();

   true_peak_meter_fir DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_peak(rsp_chan.peak);
   end

   task automatic send_sample(input sample_type s);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= s;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_sample(s);
   endtask

   // push seven samples whose signs line up with one phase's weights
   task automatic send_aligned(input bit reversed, input bit flip, input longint floor_mag);
      bit [6:0] neg_taps;
      longint   mag;
      bit       negative;
      neg_taps = reversed ? NEG_REV : NEG_FWD;
      for (int i = 0; i < 7; i++) begin
         mag = longint'($urandom_range(int'(floor_mag), 8388607));
         negative = neg_taps[i] ^ flip;
         if (negative) send_sample(sample_type'((mag == FULL_POS) ? FULL_NEG : -mag));
         else send_sample(sample_type'(mag));
      end
   endtask

   task automatic send_random_phase(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               send_aligned(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            longint'($urandom_range(0, 8000000)));
               sent += 7;
            end
            2: begin
               send_sample(sample_type'($urandom_range(0, 1) ? FULL_NEG : FULL_POS));
               sent++;
            end
            3, 4: begin
               send_sample(sample_type'(int'($urandom_range(0, 1023)) - 512));
               sent++;
            end
            default: begin
               send_sample(sample_type'($urandom));
               sent++;
            end
         endcase
      end
   endtask

   initial begin
      sb = new();
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      send_idle_pct = 30;
      recv_idle_pct = 69;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_sample(sample_type'(0));
      send_sample(sample_type'(FULL_POS));
      send_sample(sample_type'(FULL_NEG));
      send_sample(sample_type'(-1));
      send_sample(sample_type'(1));
      repeat (4) send_sample(sample_type'(FULL_NEG));
      send_aligned(1'b0, 1'b0, 64'sd8388607);
      send_aligned(1'b1, 1'b1, 64'sd8388607);

      send_random_phase(PHASE_ITEMS);
      send_idle_pct = 69;
      recv_idle_pct = 30;
      send_random_phase(PHASE_ITEMS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_phase(PHASE_ITEMS);

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.pending_peaks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
